// ===== rtl/crc_mod2_divider_defines.svh =====
// Shared assertion macros for the divider.
`ifndef CRC_MOD2_DIVIDER_DEFINES_SVH
`define CRC_MOD2_DIVIDER_DEFINES_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define CRCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks a condition that must hold in the cycle after its trigger.
`define CRCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/crcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crcd_pkg;

    localparam int DATA_W  = 32;
    localparam int DEG_W   = 6;
    localparam int PADDR_W = 3;

    localparam logic [DATA_W-1:0] POLY_LOW_RESET = 32'h0000_1021;
    localparam logic [DEG_W-1:0]  DEGREE_RESET   = 6'd16;
    localparam logic [DEG_W-1:0]  BITS_SEEN_MAX  = 6'd63;

    typedef enum logic [0:0] {
        REG_POLY_LOW = 1'b0,
        REG_DEGREE   = 1'b1
    } crcd_reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] poly_low;
        logic [DEG_W-1:0]  degree;
    } crcd_cfg_t;

    typedef struct packed {
        logic              quotient_valid;
        logic              quotient_bit;
        logic              done_res;
        logic [DATA_W-1:0] remainder;
        logic              too_short;
    } crcd_res_t;

endpackage

`default_nettype wire

// ===== rtl/crcd_bit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface crcd_bit_if;

    logic valid;
    logic ready;
    logic msg_bit;
    logic is_last;

    modport source (output valid, output msg_bit, output is_last, input ready);
    modport sink (input valid, input msg_bit, input is_last, output ready);

endinterface

`default_nettype wire

// ===== rtl/crcd_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface crcd_res_if;

    logic                      valid;
    logic                      ready;
    logic                      quotient_valid;
    logic                      quotient_bit;
    logic                      done_res;
    logic [crcd_pkg::DATA_W-1:0] remainder;
    logic                      too_short;

    modport source (
        output valid, output quotient_valid, output quotient_bit,
        output done_res, output remainder, output too_short, input ready
    );
    modport sink (
        input valid, input quotient_valid, input quotient_bit,
        input done_res, input remainder, input too_short, output ready
    );

endinterface

`default_nettype wire

// ===== rtl/crcd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcd_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crcd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [crcd_pkg::DATA_W-1:0]   pwdata,
    output logic      [crcd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output crcd_pkg::crcd_cfg_t                cfg
);
    import crcd_pkg::*;

    logic [DATA_W-1:0] poly_low_reg;
    logic [DEG_W-1:0]  degree_reg;
    logic              wr_en;
    crcd_reg_idx_t     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    // Registers sit on 4-byte boundaries, so address bit 2 selects one.
    assign idx    = crcd_reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_low_reg <= POLY_LOW_RESET;
            degree_reg   <= DEGREE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_POLY_LOW: poly_low_reg <= pwdata;
                REG_DEGREE:   degree_reg   <= pwdata[DEG_W-1:0];
                default:      poly_low_reg <= poly_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POLY_LOW: prdata = poly_low_reg;
            REG_DEGREE:   prdata = {{(DATA_W-DEG_W){1'b0}}, degree_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.poly_low = poly_low_reg;
    assign cfg.degree   = degree_reg;

endmodule

`default_nettype wire

// ===== rtl/crcd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcd_step #(
    parameter int MAX_DEGREE = 32
) (
    input  wire crcd_pkg::crcd_cfg_t          cfg,
    input  wire logic [crcd_pkg::DATA_W-1:0]  rem_cur,
    input  wire logic [crcd_pkg::DEG_W-1:0]   bits_cur,
    input  wire logic                         msg_bit,
    input  wire logic                         is_last,
    output logic      [crcd_pkg::DATA_W-1:0]  rem_new,
    output logic      [crcd_pkg::DEG_W-1:0]   bits_new,
    output crcd_pkg::crcd_res_t               res
);
    import crcd_pkg::*;

    localparam int CAP = (MAX_DEGREE < DATA_W) ? MAX_DEGREE : DATA_W;

    logic [DEG_W-1:0]  eff_deg;
    logic [DEG_W-1:0]  deg_m1;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] rem_masked;
    logic [DATA_W-1:0] shifted;
    logic              top;
    logic              full;
    logic              sub;

    // Degree zero behaves as one; anything above the cap is clamped.
    always_comb
    begin
        priority if (cfg.degree == '0)
            eff_deg = DEG_W'(1);
        else if (cfg.degree > DEG_W'(CAP))
            eff_deg = DEG_W'(CAP);
        else
            eff_deg = cfg.degree;
    end

    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            mask[i] = (DEG_W'(i) < eff_deg);
        end
    end

    assign deg_m1     = eff_deg - DEG_W'(1);
    assign rem_masked = rem_cur & mask;
    assign top        = rem_masked[deg_m1[$clog2(DATA_W)-1:0]];
    assign full       = (bits_cur >= eff_deg);
    assign sub        = full && top;
    assign shifted    = {rem_masked[DATA_W-2:0], msg_bit} & mask;

    always_comb
    begin
        logic [DATA_W-1:0] r;
        r = sub ? (shifted ^ (cfg.poly_low & mask)) : shifted;

        res.quotient_valid = full;
        res.quotient_bit   = sub;
        res.done_res       = is_last;
        res.remainder      = is_last ? r : '0;
        res.too_short      = is_last && !full;

        // The last bit of a message starts the next one from scratch.
        if (is_last)
        begin
            rem_new  = '0;
            bits_new = '0;
        end
        else
        begin
            rem_new  = r;
            bits_new = (bits_cur == BITS_SEEN_MAX) ? bits_cur : bits_cur + DEG_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crc_mod2_divider.sv =====
// A result is registered and appears in the cycle after its input bit is accepted.
// Throughput: one bit per cycle while the receiver takes results, set by the single
// shift and conditional XOR step that feeds the running remainder register.
// Reset (rst_n, asynchronous): remainder and bit count clear to zero, the
// polynomial and degree return to 0x1021 and 16, and the result slot empties.
`timescale 1ns / 1ps
`default_nettype none

`include "crc_mod2_divider_defines.svh"

module crc_mod2_divider #(
    parameter int MAX_DEGREE = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crcd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [crcd_pkg::DATA_W-1:0]   pwdata,
    output logic      [crcd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    crcd_bit_if.sink                           bit_stream,
    crcd_res_if.source                         result
);
    import crcd_pkg::*;

    crcd_cfg_t         cfg;
    logic [DATA_W-1:0] remainder_reg;
    logic [DATA_W-1:0] remainder_next;
    logic [DEG_W-1:0]  bits_seen_reg;
    logic [DEG_W-1:0]  bits_seen_next;
    crcd_res_t         res_next;
    crcd_res_t         res_reg;
    logic              out_valid_reg;
    logic              accept;

    crcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcd_step #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_step (
        .cfg      (cfg),
        .rem_cur  (remainder_reg),
        .bits_cur (bits_seen_reg),
        .msg_bit  (bit_stream.msg_bit),
        .is_last  (bit_stream.is_last),
        .rem_new  (remainder_next),
        .bits_new (bits_seen_next),
        .res      (res_next)
    );

    // A new bit is taken whenever the result slot is empty or being drained.
    assign bit_stream.ready = !out_valid_reg || result.ready;
    assign accept           = bit_stream.valid && bit_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '0;
            bits_seen_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                remainder_reg <= remainder_next;
                bits_seen_reg <= bits_seen_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.quotient_valid = res_reg.quotient_valid;
    assign result.quotient_bit   = res_reg.quotient_bit;
    assign result.done_res       = res_reg.done_res;
    assign result.remainder      = res_reg.remainder;
    assign result.too_short      = res_reg.too_short;

    `CRCD_ASSERT_NEXT(a_last_clears_state, accept && bit_stream.is_last,
        bits_seen_reg == '0 && remainder_reg == '0,
        "state not cleared after the last bit of a message")

    `CRCD_ASSERT_NEXT(a_count_advances, accept && !bit_stream.is_last,
        bits_seen_reg != '0, "bit count did not advance after a transaction")

    `CRCD_ASSERT_SAME(a_short_only_when_done, out_valid_reg && res_reg.too_short,
        res_reg.done_res && !res_reg.quotient_valid,
        "too_short flagged on a result that is not a final one")

    `CRCD_ASSERT_SAME(a_quotient_needs_valid, out_valid_reg && res_reg.quotient_bit,
        res_reg.quotient_valid, "quotient bit set before the divisor fits")

endmodule

`default_nettype wire

// ===== tb/crcd_checker.sv =====
`timescale 1ns / 1ps

module crcd_checker
    import crcd_pkg::*;
#(
    parameter int MAX_DEGREE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic [DATA_W-1:0]  prdata,
    input  logic               pready,
    crcd_bit_if                bit_mon,
    crcd_res_if                res_mon,
    output int                 fail_count,
    output int                 pending
);

    localparam int DEG_CAP = (MAX_DEGREE < DATA_W) ? MAX_DEGREE : DATA_W;
    localparam logic [PADDR_W-1:0] POLY_ADDR   = PADDR_W'(4 * REG_POLY_LOW);
    localparam logic [PADDR_W-1:0] DEGREE_ADDR = PADDR_W'(4 * REG_DEGREE);

    logic [DATA_W-1:0] poly_q;
    logic [DEG_W-1:0]  degree_q;
    logic [DATA_W-1:0] rem_q;
    logic [DEG_W-1:0]  seen_q;
    crcd_res_t         expected_q[$];
    int                res_idx;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                 res_idx, what, got, want);
        fail_count++;
    endtask

    // One step of the long division: shift the new bit into the running
    // remainder and subtract the generator when the bit falling out is set.
    task automatic divide_step(input logic b, input logic last, output crcd_res_t res);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] r;
        logic        top;
        logic        full;
        d = 32'(degree_q);
        if (d < 1) d = 1;
        if (d > DEG_CAP) d = DEG_CAP;
        mask = (64'd1 << d) - 64'd1;
        r    = {32'd0, rem_q} & mask;
        top  = r[d-1];
        full = (seen_q >= d);
        r    = ((r << 1) | {63'd0, b}) & mask;
        if (full && top) r = r ^ ({32'd0, poly_q} & mask);
        rem_q = r[DATA_W-1:0];
        if (seen_q < BITS_SEEN_MAX) seen_q = seen_q + 1'b1;
        res.quotient_valid = full;
        res.quotient_bit   = full && top;
        res.done_res       = last;
        res.remainder      = last ? r[DATA_W-1:0] : '0;
        res.too_short      = last && !full;
        if (last)
        begin
            rem_q  = '0;
            seen_q = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        crcd_res_t got;
        crcd_res_t want;
        if (!rst_n)
        begin
            poly_q     = POLY_LOW_RESET;
            degree_q   = DEGREE_RESET;
            rem_q      = '0;
            seen_q     = '0;
            expected_q.delete();
            res_idx    = 0;
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                got.quotient_valid = res_mon.quotient_valid;
                got.quotient_bit   = res_mon.quotient_bit;
                got.done_res       = res_mon.done_res;
                got.remainder      = res_mon.remainder;
                got.too_short      = res_mon.too_short;
                if (expected_q.size() == 0)
                    report_mismatch("transaction with nothing expected", '0, '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (got.quotient_valid !== want.quotient_valid)
                        report_mismatch("quotient_valid", DATA_W'(got.quotient_valid),
                                        DATA_W'(want.quotient_valid));
                    if (got.quotient_bit !== want.quotient_bit)
                        report_mismatch("quotient_bit", DATA_W'(got.quotient_bit),
                                        DATA_W'(want.quotient_bit));
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", DATA_W'(got.done_res),
                                        DATA_W'(want.done_res));
                    if (got.remainder !== want.remainder)
                        report_mismatch("remainder", got.remainder, want.remainder);
                    if (got.too_short !== want.too_short)
                        report_mismatch("too_short", DATA_W'(got.too_short),
                                        DATA_W'(want.too_short));
                end
                res_idx++;
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == POLY_ADDR)
                        poly_q = pwdata;
                    else if (paddr == DEGREE_ADDR)
                        degree_q = pwdata[DEG_W-1:0];
                end
                else if (paddr == POLY_ADDR)
                begin
                    if (prdata !== poly_q)
                        report_mismatch("poly_low read back", prdata, poly_q);
                end
                else if (paddr == DEGREE_ADDR)
                begin
                    if (prdata !== {{(DATA_W-DEG_W){1'b0}}, degree_q})
                        report_mismatch("degree read back", prdata,
                                        {{(DATA_W-DEG_W){1'b0}}, degree_q});
                end
            end

            if (bit_mon.valid && bit_mon.ready)
            begin
                divide_step(bit_mon.msg_bit, bit_mon.is_last, want);
                expected_q.push_back(want);
            end

            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import crcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 210;
    localparam logic [PADDR_W-1:0] POLY_ADDR   = PADDR_W'(4 * REG_POLY_LOW);
    localparam logic [PADDR_W-1:0] DEGREE_ADDR = PADDR_W'(4 * REG_DEGREE);

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;
    int items_sent;
    int src_idle;
    int sink_stall;
    int stall_cycles;

    crcd_bit_if bit_stream();
    crcd_res_if result();

    crc_mod2_divider #(
        .MAX_DEGREE(32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .bit_stream(bit_stream),
        .result    (result)
    );

    crcd_checker #(
        .MAX_DEGREE(32)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .bit_mon   (bit_stream),
        .res_mon   (result),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure; the stall rate follows the current phase.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // Any accepted transaction on either channel or the register port
    // counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (bit_stream.valid && bit_stream.ready) ||
            (result.valid && result.ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        bit_stream.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // The divider must be idle before its registers change; a message may
    // still be open, which checks that nothing restarts.
    task automatic set_divisor(input logic [DEG_W-1:0] deg, input logic [DATA_W-1:0] poly);
        wait_drained();
        apb_access(1'b1, POLY_ADDR, poly);
        apb_access(1'b1, DEGREE_ADDR, {{(DATA_W-DEG_W){1'b0}}, deg});
        apb_access(1'b0, POLY_ADDR, '0);
        apb_access(1'b0, DEGREE_ADDR, '0);
    endtask

    task automatic push_bit(input logic b, input logic last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            bit_stream.valid <= 1'b0;
            @(posedge clk);
        end
        bit_stream.valid   <= 1'b1;
        bit_stream.msg_bit <= b;
        bit_stream.is_last <= last;
        @(posedge clk);
        while (!bit_stream.ready) @(posedge clk);
        items_sent++;
    endtask

    // Sends a dividend whose last zero_tail bits are zero, as for a CRC.
    // Stops without the last flag once stop_at items have gone out.
    task automatic send_message(input int len, input int zero_tail, input int stop_at);
        for (int i = 0; i < len; i++)
        begin
            if (items_sent >= stop_at) break;
            push_bit((i >= len - zero_tail) ? 1'b0 : 1'($urandom_range(0, 1)), i == len - 1);
        end
    endtask

    initial
    begin
        logic [DEG_W-1:0]  deg_w;
        logic [DATA_W-1:0] poly_w;
        int d;
        int len;
        int tail;
        int pick;
        int phase_end;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        bit_stream.valid   <= 1'b0;
        bit_stream.msg_bit <= 1'b0;
        bit_stream.is_last <= 1'b0;
        items_sent = 0;
        src_idle   = 0;
        sink_stall = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset divisor: a message shorter than the generator, then a
        // one-bit message.
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b1);
        push_bit(1'b1, 1'b1);

        // Smallest degree, parity generator.
        set_divisor(6'd1, 32'h0000_0001);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b1);

        // A degree of zero behaves as one.
        set_divisor(6'd0, 32'h0000_0001);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);

        // Top degree code clamps to 32; a short message keeps its own bits.
        set_divisor(6'd63, 32'hFFFF_FFFF);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b1);

        set_divisor(6'd3, 32'h0000_0003);
        repeat (4) push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);

        // Divisor changed in the middle of a message.
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        set_divisor(6'd2, 32'h0000_0001);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 72; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 72; end
                default: begin src_idle = 19; sink_stall = 19; end
            endcase
            case (p)
                0: begin deg_w = 6'd1;  poly_w = $urandom;      end
                1: begin deg_w = 6'd32; poly_w = 32'hFFFF_FFFF; end
                2: begin deg_w = 6'd0;  poly_w = 32'h0000_0000; end
                3: begin deg_w = 6'd63; poly_w = $urandom;      end
                4: begin deg_w = 6'($urandom_range(2, 31)); poly_w = $urandom; end
                5: begin deg_w = 6'd33; poly_w = 32'h04C1_1DB7; end
                6: begin deg_w = 6'd5;  poly_w = $urandom;      end
                default: begin deg_w = 6'd16; poly_w = 32'h0000_1021; end
            endcase
            set_divisor(deg_w, poly_w);
            d = (deg_w == 0) ? 1 : ((deg_w > 32) ? 32 : int'(deg_w));

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                tail = 0;
                if (pick < 10)
                    len = $urandom_range(1, d);
                else if (pick < 16)
                    len = $urandom_range(64, 80);
                else
                begin
                    len = d + 1 + $urandom_range(0, 2 * d);
                    if (pick < 55) tail = d;
                end
                send_message(len, tail, phase_end);
                if ($urandom_range(0, 24) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
